@@ design/quad_grid_subdivider_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef QUAD_GRID_SUBDIVIDER_UNIT_ASSERT_SVH
`define QUAD_GRID_SUBDIVIDER_UNIT_ASSERT_SVH

// Checked on every edge outside reset.
`define QGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define QGS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/qgs_pkg.sv @@
package qgs_pkg;

  localparam int CW            = 24;
  localparam int PPW           = CW + 2;
  localparam int PW            = 2 * CW + 2;
  localparam int MAX_CELLS_DEF = 64;
  localparam int QDEPTH        = 2;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_CELL_W   = 2'd2;
  localparam logic [1:0] REG_CELL_H   = 2'd3;

  localparam logic [CW-2:0] CELL_RESET = (CW-1)'(25600);

  typedef struct packed {
    logic                  start;
    logic [CW-1:0]         a;
    logic signed [CW:0]    b;
    logic [CW:0]           e;
  } qgs_mdreq_t;

  typedef struct packed {
    logic                  done;
    logic [CW-1:0]         q;
    logic [CW:0]           r;
  } qgs_mdres_t;

  typedef struct packed {
    logic                  degen;
    logic                  sw;
    logic [2:0]            kind;
    logic [CW-1:0]         ql;
    logic [CW-1:0]         qt;
    logic [CW-1:0]         qr;
    logic [CW-1:0]         qb;
    logic [CW-1:0]         xs;
    logic [CW-1:0]         xe;
    logic [CW-1:0]         ys;
    logic [CW-1:0]         ye;
    logic [CW-1:0]         w;
    logic [CW-1:0]         h;
    logic [CW-2:0]         cw;
    logic [CW-2:0]         ch;
    logic [PPW-1:0]        bx1;
    logic [PPW-1:0]        by1;
    logic [CW-1:0]         q1x;
    logic [CW:0]           r1x;
    logic [CW-1:0]         qsx;
    logic [CW:0]           rsx;
    logic [CW-1:0]         q1y;
    logic [CW:0]           r1y;
    logic [CW-1:0]         qsy;
    logic [CW:0]           rsy;
  } qgs_job_t;

endpackage

@@ design/qgs_if.sv @@
interface qgs_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [qgs_pkg::CW-1:0]   quad_left;
  logic signed [qgs_pkg::CW-1:0]   quad_top;
  logic signed [qgs_pkg::CW-1:0]   quad_right;
  logic signed [qgs_pkg::CW-1:0]   quad_bottom;
  logic signed [qgs_pkg::CW-1:0]   tex_u_start;
  logic signed [qgs_pkg::CW-1:0]   tex_v_start;
  logic signed [qgs_pkg::CW-1:0]   tex_u_end;
  logic signed [qgs_pkg::CW-1:0]   tex_v_end;
  logic                            uv_swapped;
  logic [2:0]                      quad_kind;

  modport source (output valid, quad_left, quad_top, quad_right, quad_bottom,
                  tex_u_start, tex_v_start, tex_u_end, tex_v_end, uv_swapped,
                  quad_kind, input ready);
  modport sink (input valid, quad_left, quad_top, quad_right, quad_bottom,
                tex_u_start, tex_v_start, tex_u_end, tex_v_end, uv_swapped,
                quad_kind, output ready);
endinterface

interface qgs_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [qgs_pkg::CW-1:0]   sub_left;
  logic signed [qgs_pkg::CW-1:0]   sub_top;
  logic signed [qgs_pkg::CW-1:0]   sub_right;
  logic signed [qgs_pkg::CW-1:0]   sub_bottom;
  logic signed [qgs_pkg::CW-1:0]   sub_u_start;
  logic signed [qgs_pkg::CW-1:0]   sub_u_end;
  logic signed [qgs_pkg::CW-1:0]   sub_v_start;
  logic signed [qgs_pkg::CW-1:0]   sub_v_end;
  logic                            sub_uv_swapped;
  logic [2:0]                      sub_kind;
  logic                            last;
  logic                            overflow;

  modport source (output valid, sub_left, sub_top, sub_right, sub_bottom,
                  sub_u_start, sub_u_end, sub_v_start, sub_v_end,
                  sub_uv_swapped, sub_kind, last, overflow, input ready);
  modport sink (input valid, sub_left, sub_top, sub_right, sub_bottom,
                sub_u_start, sub_u_end, sub_v_start, sub_v_end,
                sub_uv_swapped, sub_kind, last, overflow, output ready);
endinterface

@@ design/quad_grid_subdivider_unit.sv @@
// A zero-size quad skips the setup; it is pushed into the job queue, loaded by the
// back end and registered at the output. A gridded quad first runs six setup steps
// on the one shared multiply-divide unit (one quotient bit per cycle); after a push
// and a job load its sub-quads follow one per cycle while the output is not
// stalled, and the next quad's setup overlaps them through a two-entry job queue.
// Reset (rst_n low, synchronous) empties queue and output; origin 0, cell size 25600.
module quad_grid_subdivider_unit #(
  parameter int MAX_CELLS = qgs_pkg::MAX_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  qgs_in_if.sink      in_if,
  qgs_out_if.source   out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = qgs_pkg::CW;

  logic [CW-1:0] ox_r, oy_r;
  logic [CW-2:0] cw_r, ch_r, cw_eff, ch_eff;

  logic              push, full, pop, empty;
  qgs_pkg::qgs_job_t wjob, rjob;

  assign cfg_pready = 1'b1;
  assign cw_eff     = (cw_r == '0) ? (CW-1)'(1) : cw_r;
  assign ch_eff     = (ch_r == '0) ? (CW-1)'(1) : ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oy_r <= '0;
      cw_r <= qgs_pkg::CELL_RESET;
      ch_r <= qgs_pkg::CELL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        qgs_pkg::REG_ORIGIN_X: ox_r <= cfg_pwdata[CW-1:0];
        qgs_pkg::REG_ORIGIN_Y: oy_r <= cfg_pwdata[CW-1:0];
        qgs_pkg::REG_CELL_W:   cw_r <= cfg_pwdata[CW-2:0];
        qgs_pkg::REG_CELL_H:   ch_r <= cfg_pwdata[CW-2:0];
        default:               ox_r <= ox_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      qgs_pkg::REG_ORIGIN_X: cfg_prdata = 32'(ox_r);
      qgs_pkg::REG_ORIGIN_Y: cfg_prdata = 32'(oy_r);
      qgs_pkg::REG_CELL_W:   cfg_prdata = 32'(cw_r);
      qgs_pkg::REG_CELL_H:   cfg_prdata = 32'(ch_r);
      default:               cfg_prdata = '0;
    endcase
  end

  qgs_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .ox    (ox_r),
    .oy    (oy_r),
    .cw    (cw_eff),
    .ch    (ch_eff),
    .push  (push),
    .full  (full),
    .job   (wjob)
  );

  qgs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wjob),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .rdata (rjob)
  );

  qgs_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .job    (rjob),
    .empty  (empty),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule

@@ design/qgs_muldiv.sv @@
// Computes floor(a * b / e) and the nonnegative remainder, e > 0.
// The product is formed in the multiply state, then divided one bit per cycle.
module qgs_muldiv (
  input  logic                clk,
  input  logic                rst_n,
  input  qgs_pkg::qgs_mdreq_t req,
  output qgs_pkg::qgs_mdres_t res
);

  localparam int CW    = qgs_pkg::CW;
  localparam int PW    = qgs_pkg::PW;
  localparam int CNT_W = $clog2(PW);

  localparam logic [1:0] MD_IDLE = 2'd0;
  localparam logic [1:0] MD_MUL  = 2'd1;
  localparam logic [1:0] MD_DIV  = 2'd2;
  localparam logic [1:0] MD_FIX  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic [PW-1:0]      dvd_r, dvd_nxt;
  logic [CW:0]        rem_r, rem_nxt;
  logic [CW-1:0]      quo_r, quo_nxt;
  logic [CW:0]        e_r, e_nxt;
  logic [CW-1:0]      a_r, a_nxt;
  logic signed [CW:0] b_r, b_nxt;

  logic signed [PW-1:0] prod;
  logic [CW+1:0]        remsh;
  logic                 ge;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    e_nxt     = e_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    prod      = $signed({1'b0, a_r}) * b_r;
    remsh     = {rem_r, dvd_r[PW-1]};
    ge        = remsh >= {1'b0, e_r};
    res.done  = 1'b0;
    res.q     = quo_r;
    res.r     = rem_r;
    unique case (state_r)
      MD_IDLE: begin
        if (req.start) begin
          a_nxt     = req.a;
          b_nxt     = req.b;
          e_nxt     = req.e;
          state_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        neg_nxt   = prod[PW-1];
        dvd_nxt   = prod[PW-1] ? PW'(-prod) : PW'(prod);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = MD_DIV;
      end
      MD_DIV: begin
        rem_nxt = ge ? (CW+1)'(remsh - {1'b0, e_r}) : remsh[CW:0];
        quo_nxt = {quo_r[CW-2:0], ge};
        dvd_nxt = {dvd_r[PW-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PW - 1)) begin
          state_nxt = MD_FIX;
        end
      end
      MD_FIX: begin
        // Turn the magnitude quotient into a floor with nonnegative remainder.
        res.done = 1'b1;
        if (neg_r && (rem_r != '0)) begin
          res.q = ~quo_r;
          res.r = e_r - rem_r;
        end else if (neg_r) begin
          res.q = -quo_r;
        end
        state_nxt = MD_IDLE;
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    e_r   <= e_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

endmodule

@@ design/qgs_front.sv @@
// Accepts a quad, sorts out the degenerate case, and runs the grid and
// interpolation setup through the shared multiply-divide unit.
module qgs_front (
  input  logic                   clk,
  input  logic                   rst_n,
  qgs_in_if.sink                 in_if,
  input  logic [qgs_pkg::CW-1:0] ox,
  input  logic [qgs_pkg::CW-1:0] oy,
  input  logic [qgs_pkg::CW-2:0] cw,
  input  logic [qgs_pkg::CW-2:0] ch,
  output logic                   push,
  input  logic                   full,
  output qgs_pkg::qgs_job_t      job
);

  localparam int CW  = qgs_pkg::CW;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_REQ  = 2'd1;
  localparam logic [1:0] F_WAIT = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  localparam logic [2:0] OP_GRID_X  = 3'd0;
  localparam logic [2:0] OP_GRID_Y  = 3'd1;
  localparam logic [2:0] OP_FIRST_X = 3'd2;
  localparam logic [2:0] OP_STEP_X  = 3'd3;
  localparam logic [2:0] OP_FIRST_Y = 3'd4;
  localparam logic [2:0] OP_STEP_Y  = 3'd5;

  logic [1:0]    state_r;
  logic [2:0]    op_r;
  qgs_pkg::qgs_job_t job_r;
  logic [CW:0]   remx_r, remy_r;

  qgs_pkg::qgs_mdreq_t req;
  qgs_pkg::qgs_mdres_t res;

  logic signed [CW:0] dx, dy, gx, gy;
  logic [CW-2:0]      t1x, t1y;
  logic               in_degen;

  assign in_if.ready = (state_r == F_IDLE);
  assign push        = (state_r == F_PUSH) && !full;
  assign job         = job_r;

  assign in_degen = ($signed(in_if.quad_right) <= $signed(in_if.quad_left)) ||
                    ($signed(in_if.quad_bottom) <= $signed(in_if.quad_top));

  assign dx  = $signed({job_r.xe[CW-1], job_r.xe}) - $signed({job_r.xs[CW-1], job_r.xs});
  assign dy  = $signed({job_r.ye[CW-1], job_r.ye}) - $signed({job_r.ys[CW-1], job_r.ys});
  assign gx  = $signed({job_r.ql[CW-1], job_r.ql}) - $signed({ox[CW-1], ox});
  assign gy  = $signed({job_r.qt[CW-1], job_r.qt}) - $signed({oy[CW-1], oy});
  assign t1x = cw - remx_r[CW-2:0];
  assign t1y = ch - remy_r[CW-2:0];

  always_comb begin
    req.start = (state_r == F_REQ);
    req.a     = CW'(1);
    req.b     = gx;
    req.e     = {2'b00, cw};
    unique case (op_r)
      OP_GRID_X: begin
        req.b = gx;
        req.e = {2'b00, cw};
      end
      OP_GRID_Y: begin
        req.b = gy;
        req.e = {2'b00, ch};
      end
      OP_FIRST_X: begin
        req.a = {1'b0, t1x};
        req.b = dx;
        req.e = {1'b0, job_r.w};
      end
      OP_STEP_X: begin
        req.a = {1'b0, cw};
        req.b = dx;
        req.e = {1'b0, job_r.w};
      end
      OP_FIRST_Y: begin
        req.a = {1'b0, t1y};
        req.b = dy;
        req.e = {1'b0, job_r.h};
      end
      OP_STEP_Y: begin
        req.a = {1'b0, ch};
        req.b = dy;
        req.e = {1'b0, job_r.h};
      end
      default: begin
        req.a = CW'(1);
      end
    endcase
  end

  qgs_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      op_r    <= OP_GRID_X;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_if.valid) begin
            op_r    <= OP_GRID_X;
            state_r <= in_degen ? F_PUSH : F_REQ;
          end
        end
        F_REQ: state_r <= F_WAIT;
        F_WAIT: begin
          if (res.done) begin
            if (op_r == OP_STEP_Y) begin
              state_r <= F_PUSH;
            end else begin
              op_r    <= op_r + 3'd1;
              state_r <= F_REQ;
            end
          end
        end
        F_PUSH: begin
          if (!full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      job_r.degen <= in_degen;
      job_r.sw    <= in_if.uv_swapped;
      job_r.kind  <= in_if.quad_kind;
      job_r.ql    <= in_if.quad_left;
      job_r.qt    <= in_if.quad_top;
      job_r.qr    <= in_if.quad_right;
      job_r.qb    <= in_if.quad_bottom;
      // The x axis carries u unless swapped; the back end undoes the swap.
      job_r.xs    <= in_if.uv_swapped ? in_if.tex_v_start : in_if.tex_u_start;
      job_r.xe    <= in_if.uv_swapped ? in_if.tex_v_end : in_if.tex_u_end;
      job_r.ys    <= in_if.uv_swapped ? in_if.tex_u_start : in_if.tex_v_start;
      job_r.ye    <= in_if.uv_swapped ? in_if.tex_u_end : in_if.tex_v_end;
      job_r.w     <= CW'(in_if.quad_right - in_if.quad_left);
      job_r.h     <= CW'(in_if.quad_bottom - in_if.quad_top);
      job_r.cw    <= cw;
      job_r.ch    <= ch;
    end
    if (state_r == F_WAIT && res.done) begin
      unique case (op_r)
        OP_GRID_X:  remx_r <= res.r;
        OP_GRID_Y:  remy_r <= res.r;
        OP_FIRST_X: begin
          job_r.q1x <= res.q;
          job_r.r1x <= res.r;
          job_r.bx1 <= {{2{job_r.ql[CW-1]}}, job_r.ql} + {3'b000, t1x};
        end
        OP_STEP_X: begin
          job_r.qsx <= res.q;
          job_r.rsx <= res.r;
        end
        OP_FIRST_Y: begin
          job_r.q1y <= res.q;
          job_r.r1y <= res.r;
          job_r.by1 <= {{2{job_r.qt[CW-1]}}, job_r.qt} + {3'b000, t1y};
        end
        OP_STEP_Y: begin
          job_r.qsy <= res.q;
          job_r.rsy <= res.r;
        end
        default: begin
          job_r.qsy <= res.q;
        end
      endcase
    end
  end

endmodule

@@ design/qgs_queue.sv @@
// Short FIFO of set-up jobs between the front and back ends.
module qgs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qgs_pkg::qgs_job_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output qgs_pkg::qgs_job_t rdata
);

  localparam int DEPTH = qgs_pkg::QDEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qgs_pkg::qgs_job_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_r, rd_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

@@ design/qgs_back.sv @@
// Walks one job's cells, one sub-quad per cycle unless the output stalls;
// each axis steps its texture value with a quotient/remainder accumulator.
module qgs_back #(
  parameter int MAX_CELLS = qgs_pkg::MAX_CELLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qgs_pkg::qgs_job_t job,
  input  logic              empty,
  output logic              pop,
  qgs_out_if.source         out_if
);

  localparam int CW  = qgs_pkg::CW;
  localparam int PPW = qgs_pkg::PPW;
  localparam int NW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  logic            busy_r, ov_r;
  logic [NW-1:0]   n_r;
  logic [PPW-1:0]  xpos_r, ypos_r;
  logic [CW-1:0]   xdq_r, ydq_r, x0_r, y0_r, xv0_r, yv0_r;
  logic [CW:0]     xdr_r, ydr_r;

  logic [CW-1:0]   o_l_r, o_t_r, o_r_r, o_b_r, o_us_r, o_ue_r, o_vs_r, o_ve_r;
  logic            o_sw_r, o_last_r, o_ovf_r;
  logic [2:0]      o_kind_r;

  logic            xlast, ylast, nat_last, cap, fin, emit;
  logic [CW-1:0]   x1, y1, xv1, yv1;
  logic [CW+1:0]   xsum, ysum;
  logic            xwrap, ywrap;

  assign xlast    = job.degen ||
                    ($signed(xpos_r) >= $signed({{2{job.qr[CW-1]}}, job.qr}));
  assign ylast    = job.degen ||
                    ($signed(ypos_r) >= $signed({{2{job.qb[CW-1]}}, job.qb}));
  assign x1       = xlast ? job.qr : xpos_r[CW-1:0];
  assign y1       = ylast ? job.qb : ypos_r[CW-1:0];
  assign xv1      = xlast ? job.xe : job.xs + xdq_r;
  assign yv1      = ylast ? job.ye : job.ys + ydq_r;
  assign nat_last = xlast && ylast;
  assign cap      = (n_r == NW'(MAX_CELLS - 1));
  assign fin      = nat_last || cap;
  assign emit     = busy_r && (!ov_r || out_if.ready);
  assign pop      = emit && fin;

  assign xsum  = {1'b0, xdr_r} + {1'b0, job.rsx};
  assign ysum  = {1'b0, ydr_r} + {1'b0, job.rsy};
  assign xwrap = xsum >= {2'b00, job.w};
  assign ywrap = ysum >= {2'b00, job.h};

  assign out_if.valid          = ov_r;
  assign out_if.sub_left       = o_l_r;
  assign out_if.sub_top        = o_t_r;
  assign out_if.sub_right      = o_r_r;
  assign out_if.sub_bottom     = o_b_r;
  assign out_if.sub_u_start    = o_us_r;
  assign out_if.sub_u_end      = o_ue_r;
  assign out_if.sub_v_start    = o_vs_r;
  assign out_if.sub_v_end      = o_ve_r;
  assign out_if.sub_uv_swapped = o_sw_r;
  assign out_if.sub_kind       = o_kind_r;
  assign out_if.last           = o_last_r;
  assign out_if.overflow       = o_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      n_r    <= '0;
    end else begin
      if (emit) begin
        ov_r <= 1'b1;
        n_r  <= n_r + 1'b1;
        if (fin) begin
          busy_r <= 1'b0;
        end
      end else if (out_if.ready) begin
        ov_r <= 1'b0;
      end
      if (!busy_r && !empty) begin
        busy_r <= 1'b1;
        n_r    <= '0;
      end
    end

    if (!busy_r && !empty) begin
      x0_r   <= job.ql;
      xv0_r  <= job.xs;
      xpos_r <= job.bx1;
      xdq_r  <= job.q1x;
      xdr_r  <= job.r1x;
      y0_r   <= job.qt;
      yv0_r  <= job.ys;
      ypos_r <= job.by1;
      ydq_r  <= job.q1y;
      ydr_r  <= job.r1y;
    end else if (emit && !fin) begin
      if (xlast) begin
        // Start the next row: x restarts, y moves down one boundary.
        x0_r   <= job.ql;
        xv0_r  <= job.xs;
        xpos_r <= job.bx1;
        xdq_r  <= job.q1x;
        xdr_r  <= job.r1x;
        y0_r   <= ypos_r[CW-1:0];
        yv0_r  <= job.ys + ydq_r;
        ypos_r <= ypos_r + {3'b000, job.ch};
        ydq_r  <= ydq_r + job.qsy + CW'(ywrap);
        ydr_r  <= ywrap ? (CW+1)'(ysum - {2'b00, job.h}) : ysum[CW:0];
      end else begin
        x0_r   <= xpos_r[CW-1:0];
        xv0_r  <= job.xs + xdq_r;
        xpos_r <= xpos_r + {3'b000, job.cw};
        xdq_r  <= xdq_r + job.qsx + CW'(xwrap);
        xdr_r  <= xwrap ? (CW+1)'(xsum - {2'b00, job.w}) : xsum[CW:0];
      end
    end

    if (emit) begin
      o_l_r    <= x0_r;
      o_t_r    <= y0_r;
      o_r_r    <= x1;
      o_b_r    <= y1;
      o_us_r   <= job.sw ? yv0_r : xv0_r;
      o_ue_r   <= job.sw ? yv1 : xv1;
      o_vs_r   <= job.sw ? xv0_r : yv0_r;
      o_ve_r   <= job.sw ? xv1 : yv1;
      o_sw_r   <= job.sw;
      o_kind_r <= job.kind;
      o_last_r <= fin;
      o_ovf_r  <= cap && !nat_last;
    end
  end

endmodule

@@ design/qgs_checker.sv @@
`include "quad_grid_subdivider_unit_assert.svh"

module qgs_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic out_overflow
);

  // A stalled word keeps its place.
  `QGS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_last), "output word dropped while stalled")
  // Overflow is only reported on the closing word of a quad.
  `QGS_ASSERT(a_ovf_last, out_valid && out_overflow |-> out_last, "overflow without last")
  // Reset empties the output.
  `QGS_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind quad_grid_subdivider_unit qgs_checker u_qgs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_last     (out_if.last),
  .out_overflow (out_if.overflow)
);
